// File: rtl/core/vc28_pkg.sv
// ----------------------------------------------------------------------------
// vc28_pkg
// Shared types, constants and helper functions for the 28-symbol Vigenere
// cipher unit.
// ----------------------------------------------------------------------------
package vc28_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned SYM_W    = 5;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned KEY_W    = 60;
    localparam int unsigned NUM_SYMS = 28;
    localparam int unsigned HALF_KEY = 12;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [POS_W-1:0]  t_pos;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd3;

    // Operating modes.
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Special characters.
    localparam t_char CHAR_SPACE = 8'd32;
    localparam t_char CHAR_DOT   = 8'd46;
    localparam t_char CHAR_UP_A  = 8'd65;
    localparam t_char CHAR_UP_Z  = 8'd90;
    localparam t_char CHAR_LO_A  = 8'd97;
    localparam t_char CHAR_LO_Z  = 8'd122;
    localparam t_char CASE_DIFF  = 8'd32;

    localparam t_sym SYM_SPACE = 5'd26;
    localparam t_sym SYM_DOT   = 5'd27;

    // Reduce a value below twice the alphabet size into 0..27.
    function automatic t_sym mod_syms(input logic [SYM_W:0] v);
        logic [SYM_W:0] r;
        r = (v >= (SYM_W+1)'(NUM_SYMS)) ? v - (SYM_W+1)'(NUM_SYMS) : v;
        return r[SYM_W-1:0];
    endfunction

    // Symbol index of a byte: A-Z map to 0..25, space and dot to 26 and 27,
    // everything else to 0.
    function automatic t_sym symbol_index(input t_char b);
        t_char d;
        d = b - CHAR_UP_A;
        if (b == CHAR_SPACE) begin
            return SYM_SPACE;
        end else if (b == CHAR_DOT) begin
            return SYM_DOT;
        end else if (b >= CHAR_UP_A && b <= CHAR_UP_Z) begin
            return d[SYM_W-1:0];
        end
        return '0;
    endfunction

    // Character of the alphabet at a symbol index.
    function automatic t_char alphabet(input t_sym s);
        t_char c;
        if (s == SYM_SPACE) begin
            c = CHAR_SPACE;
        end else if (s == SYM_DOT) begin
            c = CHAR_DOT;
        end else begin
            c = CHAR_UP_A + CHAR_W'(s);
        end
        return c;
    endfunction

endpackage

// File: rtl/core/vigenere_cipher_28_symbol_unit.sv
// ----------------------------------------------------------------------------
// vigenere_cipher_28_symbol_unit
// Byte-stream Vigenere cipher over the alphabet A-Z, space and dot.
// ----------------------------------------------------------------------------
// The unit takes one message byte per item and returns one transformed byte
// per item, in order. Space and dot pass through unchanged; every other byte
// is mapped to a symbol (encrypt mode uppercases a-z first, anything that is
// not A-Z becomes symbol 0) and shifted by the current key symbol modulo 28.
// The key position advances on every byte and returns to zero after a byte
// marked last. The datapath is two registers deep: an input register that
// captures the byte together with the key position it uses, and a result
// register. An item can be accepted in every cycle while the result register
// can load, so the sustained rate is one item per clock unless the output
// stalls. A result passes the input register and then the result register
// before it is valid. The key position counter is the only loop-carried
// state and it resolves in the same cycle an item is accepted. Configuration
// registers must only be written while no item is in flight.
// ----------------------------------------------------------------------------
module vigenere_cipher_28_symbol_unit #(
    parameter int unsigned MAX_KEY_LEN = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [vc28_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vc28_pkg::KEY_W-1:0]       i_cfg_data,

    // Input item channel.
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [vc28_pkg::CHAR_W-1:0]      i_in_char,
    input  logic                             i_last_char,

    // Result item channel.
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [vc28_pkg::CHAR_W-1:0]      o_out_char,
    output logic                             o_end_of_message
);

    localparam vc28_pkg::t_pos MaxLen = vc28_pkg::POS_W'(MAX_KEY_LEN);
    localparam int unsigned NumKeySyms = 2 * vc28_pkg::HALF_KEY;

    // Configuration registers.
    logic                           r_mode;
    vc28_pkg::t_pos                 r_key_length;
    logic [vc28_pkg::KEY_W-1:0]     r_key_low;
    logic [vc28_pkg::KEY_W-1:0]     r_key_high;

    // Key position counter.
    vc28_pkg::t_pos                 r_key_pos;
    vc28_pkg::t_pos                 n_key_pos;

    // Input stage.
    logic                           r_s1_valid;
    vc28_pkg::t_char                r_s1_char;
    logic                           r_s1_last;
    vc28_pkg::t_pos                 r_s1_pos;

    // Result stage.
    logic                           r_out_valid;
    vc28_pkg::t_char                r_out_char;
    logic                           r_out_last;
    vc28_pkg::t_char                n_out_char;

    logic                           in_accept;
    logic                           s2_ready;
    logic                           s1_ready;
    vc28_pkg::t_pos                 eff_len;
    vc28_pkg::t_pos                 pos_used;
    vc28_pkg::t_pos                 pos_inc;

    vc28_pkg::t_sym                 key_syms [NumKeySyms];
    vc28_pkg::t_sym                 key_sym;
    vc28_pkg::t_char                s1_byte;
    vc28_pkg::t_sym                 plain_sym;
    logic [vc28_pkg::SYM_W:0]       shift_sum;

    // ------------------------------------------------------------------
    // Handshake. The result register frees up when its item is taken, and
    // the input stage moves forward whenever the result register can load.
    // ------------------------------------------------------------------
    assign s2_ready   = !r_out_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;
    assign in_accept  = i_in_valid && s1_ready;

    // ------------------------------------------------------------------
    // Key position. A key length of zero acts as one and a length above
    // the maximum is clamped. A position that is past the current length,
    // which can happen when the length shrinks mid-message, restarts at 0.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_key_length == '0) begin
            eff_len = vc28_pkg::POS_W'(1);
        end else if (r_key_length > MaxLen) begin
            eff_len = MaxLen;
        end else begin
            eff_len = r_key_length;
        end

        pos_used = (r_key_pos < eff_len) ? r_key_pos : '0;
        pos_inc  = pos_used + vc28_pkg::POS_W'(1);

        if (i_last_char || pos_inc >= eff_len) begin
            n_key_pos = '0;
        end else begin
            n_key_pos = pos_inc;
        end
    end

    // ------------------------------------------------------------------
    // Cipher datapath between the input stage and the result register.
    // Key symbols 28 to 31 are reduced modulo 28 before use.
    // ------------------------------------------------------------------
    always_comb begin
        for (int j = 0; j < vc28_pkg::HALF_KEY; j++) begin
            key_syms[j]                     = r_key_low[j*vc28_pkg::SYM_W +: vc28_pkg::SYM_W];
            key_syms[j + vc28_pkg::HALF_KEY] =
                r_key_high[j*vc28_pkg::SYM_W +: vc28_pkg::SYM_W];
        end
        key_sym = vc28_pkg::mod_syms({1'b0, key_syms[r_s1_pos]});

        // Encrypt mode folds lowercase letters to uppercase first.
        if (r_mode == vc28_pkg::MODE_ENCRYPT
                && r_s1_char >= vc28_pkg::CHAR_LO_A
                && r_s1_char <= vc28_pkg::CHAR_LO_Z) begin
            s1_byte = r_s1_char - vc28_pkg::CASE_DIFF;
        end else begin
            s1_byte = r_s1_char;
        end

        plain_sym = vc28_pkg::symbol_index(s1_byte);

        if (r_mode == vc28_pkg::MODE_ENCRYPT) begin
            shift_sum = {1'b0, plain_sym} + {1'b0, key_sym};
        end else begin
            shift_sum = {1'b0, plain_sym} + (vc28_pkg::SYM_W+1)'(vc28_pkg::NUM_SYMS)
                        - {1'b0, key_sym};
        end

        // Space and dot always pass through unchanged.
        if (s1_byte == vc28_pkg::CHAR_SPACE || s1_byte == vc28_pkg::CHAR_DOT) begin
            n_out_char = s1_byte;
        end else begin
            n_out_char = vc28_pkg::alphabet(vc28_pkg::mod_syms(shift_sum));
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= vc28_pkg::MODE_ENCRYPT;
            r_key_length <= vc28_pkg::POS_W'(1);
            r_key_low    <= '0;
            r_key_high   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vc28_pkg::CFG_MODE:       r_mode       <= i_cfg_data[0];
                vc28_pkg::CFG_KEY_LENGTH: r_key_length <= i_cfg_data[vc28_pkg::POS_W-1:0];
                vc28_pkg::CFG_KEY_LOW:    r_key_low    <= i_cfg_data;
                vc28_pkg::CFG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state: key position and stage valid flags.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_key_pos <= n_key_pos;
            end
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_char <= i_in_char;
            r_s1_last <= i_last_char;
            r_s1_pos  <= pos_used;
        end
        if (s2_ready && r_s1_valid) begin
            r_out_char <= n_out_char;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_char       = r_out_char;
    assign o_end_of_message = r_out_last;

endmodule
